[hw/rtl/mmrc_pkg.sv]
// Shared types, codes and constants for the meter response checker.
package mmrc_pkg;

  localparam int COUNT_BITS  = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int DATA_LEN = 20;
  localparam int POS_W    = 5;
  localparam int IDX_W    = $clog2(DATA_LEN);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int RES_W      = 32;

  localparam logic [1:0] ACT_POLL    = 2'd0;
  localparam logic [1:0] ACT_BYTE    = 2'd1;
  localparam logic [1:0] ACT_TIMEOUT = 2'd2;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_TIMEOUT     = 3'd1;
  localparam logic [2:0] ST_BAD_HEADER  = 3'd2;
  localparam logic [2:0] ST_CRC         = 3'd3;
  localparam logic [2:0] ST_IMPLAUSIBLE = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_METER_ADDR     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VOLTAGE_DV = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CURRENT_MA = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_POWER_DW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FAIL_LIMIT     = 3'd4;

  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [7:0]  FUNC_CODE  = 8'h04;
  localparam logic [7:0]  BYTE_COUNT = 8'd20;
  localparam logic [15:0] ALARM_SET  = 16'hFFFF;
  localparam logic [15:0] FREQ_MIN_DHZ = 16'd400;
  localparam logic [15:0] FREQ_MAX_DHZ = 16'd700;
  localparam logic [15:0] PF_MAX_C     = 16'd100;

  localparam logic [POS_W-1:0] POS_CRC_LOW  = 5'd23;
  localparam logic [POS_W-1:0] POS_CRC_HIGH = 5'd24;
  localparam logic [POS_W-1:0] POS_DATA     = 5'd3;

  typedef struct packed {
    logic [7:0]  meter_addr;
    logic [15:0] max_voltage_dv;
    logic [31:0] max_current_ma;
    logic [31:0] max_power_dw;
    logic [7:0]  fail_limit;
  } cfg_t;

  typedef struct packed {
    logic        timeout;
    logic        header_good;
    logic        crc_ok;
    logic [15:0] voltage;
    logic [31:0] current;
    logic [31:0] power;
    logic [31:0] energy;
    logic [15:0] freq;
    logic [15:0] pf;
    logic        alarm;
  } job_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[hw/rtl/mmrc_front.sv]
// Front end: frame tracking, CRC, header check and payload capture per byte beat.
module mmrc_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [1:0]            action,
  input  logic [7:0]            rx_byte,
  input  logic [7:0]            meter_addr,
  output logic                  push,
  output mmrc_pkg::job_t        job
);

  logic [mmrc_pkg::POS_W-1:0] byte_position;
  logic                       frame_active;
  logic [15:0]                running_crc;
  logic                       header_good;
  logic [7:0]                 crc_low_byte;
  logic [7:0]                 payload_bytes [mmrc_pkg::DATA_LEN];

  logic [mmrc_pkg::POS_W-1:0] data_pos;
  logic                       hdr_bad;
  logic [15:0]                r [10];

  assign data_pos = byte_position - mmrc_pkg::POS_DATA;

  always_comb begin
    hdr_bad = ((byte_position == 5'd0) && (rx_byte != meter_addr)) ||
              ((byte_position == 5'd1) && (rx_byte != mmrc_pkg::FUNC_CODE)) ||
              ((byte_position == 5'd2) && (rx_byte != mmrc_pkg::BYTE_COUNT));
  end

  always_comb begin
    for (int i = 0; i < 10; i++) begin
      r[i] = {payload_bytes[2*i], payload_bytes[2*i+1]};
    end
  end

  always_comb begin
    job.timeout     = (action == mmrc_pkg::ACT_TIMEOUT);
    job.header_good = header_good;
    job.crc_ok      = ({rx_byte, crc_low_byte} == running_crc);
    job.voltage     = r[0];
    job.current     = {r[2], r[1]};
    job.power       = {r[4], r[3]};
    job.energy      = {r[6], r[5]};
    job.freq        = r[7];
    job.pf          = r[8];
    job.alarm       = (r[9] == mmrc_pkg::ALARM_SET);
  end

  always_comb begin
    push = 1'b0;
    if (accept && frame_active) begin
      if (action == mmrc_pkg::ACT_TIMEOUT) begin
        push = 1'b1;
      end else if (action == mmrc_pkg::ACT_BYTE && byte_position > mmrc_pkg::POS_CRC_LOW) begin
        push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      frame_active  <= 1'b0;
      running_crc   <= mmrc_pkg::CRC_INIT;
      header_good   <= 1'b1;
      crc_low_byte  <= '0;
    end else if (accept) begin
      unique case (action)
        mmrc_pkg::ACT_POLL: begin
          byte_position <= '0;
          frame_active  <= 1'b1;
          running_crc   <= mmrc_pkg::CRC_INIT;
          header_good   <= 1'b1;
          crc_low_byte  <= '0;
        end
        mmrc_pkg::ACT_TIMEOUT: begin
          frame_active <= 1'b0;
        end
        mmrc_pkg::ACT_BYTE: begin
          if (frame_active) begin
            if (byte_position < mmrc_pkg::POS_CRC_LOW) begin
              running_crc   <= mmrc_pkg::crc_feed(running_crc, rx_byte);
              if (hdr_bad) begin
                header_good <= 1'b0;
              end
              byte_position <= byte_position + 5'd1;
            end else if (byte_position == mmrc_pkg::POS_CRC_LOW) begin
              crc_low_byte  <= rx_byte;
              byte_position <= mmrc_pkg::POS_CRC_HIGH;
            end else begin
              frame_active  <= 1'b0;
              byte_position <= '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && action == mmrc_pkg::ACT_BYTE && frame_active &&
        byte_position >= mmrc_pkg::POS_DATA && byte_position < mmrc_pkg::POS_CRC_LOW) begin
      payload_bytes[data_pos[mmrc_pkg::IDX_W-1:0]] <= rx_byte;
    end
  end

endmodule

[hw/rtl/mmrc_queue.sv]
// Short job queue between front and back.
module mmrc_queue #(
  parameter int DEPTH = mmrc_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mmrc_pkg::job_t push_job,
  input  logic           pop,
  output mmrc_pkg::job_t head,
  output logic           empty,
  output logic           full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mmrc_pkg::job_t   entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CNT_W'(DEPTH));
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

[hw/rtl/mmrc_back.sv]
// Back end: judges queued frames, updates readings and counters, holds the result beat.
module mmrc_back #(
  parameter int COUNT_BITS = mmrc_pkg::COUNT_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  mmrc_pkg::cfg_t        cfg,
  input  mmrc_pkg::job_t        job,
  input  logic                  q_empty,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            status,
  output logic [15:0]           voltage_dv,
  output logic [31:0]           current_ma,
  output logic [31:0]           power_dw,
  output logic [31:0]           meter_energy,
  output logic [15:0]           freq_dhz,
  output logic [6:0]            power_factor_c,
  output logic                  alarm,
  output logic                  data_valid,
  output logic [COUNT_BITS-1:0] good_count,
  output logic [COUNT_BITS-1:0] fail_count
);

  logic [7:0] consecutive_failures;
  logic [7:0] fail_run_next;
  logic       implausible;
  logic       freq_ok;
  logic [2:0] status_next;

  assign pop = !q_empty && (!out_valid || !out_stall);

  assign freq_ok = (job.freq == 16'd0) ||
                   ((job.freq >= mmrc_pkg::FREQ_MIN_DHZ) && (job.freq <= mmrc_pkg::FREQ_MAX_DHZ));

  assign implausible = (job.voltage > cfg.max_voltage_dv) ||
                       (job.current > cfg.max_current_ma) ||
                       (job.power > cfg.max_power_dw) ||
                       !freq_ok || (job.pf > mmrc_pkg::PF_MAX_C);

  assign fail_run_next = (consecutive_failures == 8'hFF) ? consecutive_failures
                                                         : consecutive_failures + 8'd1;

  always_comb begin
    priority if (job.timeout) begin
      status_next = mmrc_pkg::ST_TIMEOUT;
    end else if (!job.header_good) begin
      status_next = mmrc_pkg::ST_BAD_HEADER;
    end else if (!job.crc_ok) begin
      status_next = mmrc_pkg::ST_CRC;
    end else if (implausible) begin
      status_next = mmrc_pkg::ST_IMPLAUSIBLE;
    end else begin
      status_next = mmrc_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid            <= 1'b0;
      consecutive_failures <= '0;
      data_valid           <= 1'b0;
      good_count           <= '0;
      fail_count           <= '0;
      voltage_dv           <= '0;
      current_ma           <= '0;
      power_dw             <= '0;
      meter_energy         <= '0;
      freq_dhz             <= '0;
      power_factor_c       <= '0;
      alarm                <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
      status    <= status_next;
      if (status_next == mmrc_pkg::ST_OK) begin
        consecutive_failures <= '0;
        data_valid           <= 1'b1;
        good_count           <= good_count + COUNT_BITS'(1);
        voltage_dv           <= job.voltage;
        current_ma           <= job.current;
        power_dw             <= job.power;
        meter_energy         <= job.energy;
        freq_dhz             <= job.freq;
        power_factor_c       <= job.pf[6:0];
        alarm                <= job.alarm;
      end else begin
        consecutive_failures <= fail_run_next;
        fail_count           <= fail_count + COUNT_BITS'(1);
        if (fail_run_next > cfg.fail_limit) begin
          data_valid <= 1'b0;
        end
      end
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

[hw/rtl/modbus_meter_response_checker_unit.sv]
// Top level of the meter response checker: configuration registers, front, queue and back.
// Takes one beat per clock (poll start, received byte or response timeout). The front handles
// a beat in the cycle it is taken and writes a closing CRC byte or a timeout into the job
// queue at that edge; the back pops the head job when its result register is free or
// not stalled, judges it and registers the result beat. The input stalls only when the
// two-entry job queue is full, which happens only after the result side has stalled, so the
// sustained rate is one beat a cycle.
module modbus_meter_response_checker_unit #(
  parameter int COUNT_BITS = mmrc_pkg::COUNT_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [mmrc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mmrc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       action,
  input  logic [7:0]                       rx_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [2:0]                       status,
  output logic [15:0]                      voltage_dv,
  output logic [31:0]                      current_ma,
  output logic [31:0]                      power_dw,
  output logic [31:0]                      meter_energy,
  output logic [15:0]                      freq_dhz,
  output logic [6:0]                       power_factor_c,
  output logic                             alarm,
  output logic                             data_valid,
  output logic [31:0]                      good_frames,
  output logic [31:0]                      failed_frames
);

  mmrc_pkg::cfg_t         cfg;
  mmrc_pkg::job_t         push_job;
  mmrc_pkg::job_t         head_job;
  logic                   q_push;
  logic                   q_pop;
  logic                   q_empty;
  logic                   q_full;
  logic                   in_accept;
  logic [COUNT_BITS-1:0]  good_count;
  logic [COUNT_BITS-1:0]  fail_count;

  assign in_stall  = q_full;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.meter_addr     <= 8'd1;
      cfg.max_voltage_dv <= 16'd3000;
      cfg.max_current_ma <= 32'd100000;
      cfg.max_power_dw   <= 32'd250000;
      cfg.fail_limit     <= 8'd5;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mmrc_pkg::CFG_METER_ADDR:     cfg.meter_addr     <= cfg_data[7:0];
        mmrc_pkg::CFG_MAX_VOLTAGE_DV: cfg.max_voltage_dv <= cfg_data[15:0];
        mmrc_pkg::CFG_MAX_CURRENT_MA: cfg.max_current_ma <= cfg_data[31:0];
        mmrc_pkg::CFG_MAX_POWER_DW:   cfg.max_power_dw   <= cfg_data[31:0];
        mmrc_pkg::CFG_FAIL_LIMIT:     cfg.fail_limit     <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  mmrc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (in_accept),
    .action        (action),
    .rx_byte       (rx_byte),
    .meter_addr    (cfg.meter_addr),
    .push          (q_push),
    .job           (push_job)
  );

  mmrc_queue #(
    .DEPTH (mmrc_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head     (head_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  mmrc_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .job            (head_job),
    .q_empty        (q_empty),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .voltage_dv     (voltage_dv),
    .current_ma     (current_ma),
    .power_dw       (power_dw),
    .meter_energy   (meter_energy),
    .freq_dhz       (freq_dhz),
    .power_factor_c (power_factor_c),
    .alarm          (alarm),
    .data_valid     (data_valid),
    .good_count     (good_count),
    .fail_count     (fail_count)
  );

  assign good_frames   = mmrc_pkg::RES_W'(good_count);
  assign failed_frames = mmrc_pkg::RES_W'(fail_count);

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("job pushed into a full queue");

  a_ok_sets_valid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == mmrc_pkg::ST_OK) |-> data_valid)
    else $error("good frame reported without data valid");

  a_counters_hold: assert property (@(posedge clk) disable iff (rst)
    (!q_pop && !rst) |=> ($stable(good_frames) && $stable(failed_frames)))
    else $error("frame counters moved without a judged job");

  a_pop_loads_result: assert property (@(posedge clk) disable iff (rst)
    (q_pop && !rst) |=> out_valid)
    else $error("judged job left no result beat");

endmodule
